// ===== src/slm_pkg.sv =====
// Shared types and constants for the sorted list merge block.
`default_nettype none
package slm_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int CNT_W          = 6;   // list fill counts
  localparam int POS_W          = 6;   // merged position field
  localparam int VAL_W          = 32;
  localparam int REQ_W          = 2;
  localparam int S_TDATA_W      = 32;  // value
  localparam int M_TDATA_W      = 40;  // position, value_res, zero pad

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND_A = 2'd0,
    REQ_APPEND_B = 2'd1,
    REQ_START    = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_OUT
  } merge_state_t;

  // Merge command from the load side to the merge sequencer.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic             dropped;
  } merge_cmd_t;

endpackage
`default_nettype wire

// ===== src/slm_list_mem.sv =====
// One list buffer: single write port, single registered read port.
`default_nettype none
module slm_list_mem #(
  parameter int DEPTH = slm_pkg::LIST_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [slm_pkg::VAL_W-1:0] wr_data,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [slm_pkg::VAL_W-1:0] rd_data
);

  logic [slm_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/slm_merge_ctrl.sv =====
// Merge sequencer: walks both list tails with one shared compare, one result at a time.
`default_nettype none
module slm_merge_ctrl #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire slm_pkg::merge_cmd_t           cmd,
  output logic                               idle,
  output logic      [AW-1:0]                 rd_addr_a,
  output logic      [AW-1:0]                 rd_addr_b,
  input  wire logic [slm_pkg::VAL_W-1:0]     rd_data_a,
  input  wire logic [slm_pkg::VAL_W-1:0]     rd_data_b,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [slm_pkg::POS_W-1:0]     out_position,
  output logic      [slm_pkg::VAL_W-1:0]     out_value,
  output logic                               out_last,
  output logic                               out_dropped
);

  localparam int CW = slm_pkg::CNT_W;
  localparam int PW = slm_pkg::POS_W + 1;  // remaining count, up to twice the depth

  slm_pkg::merge_state_t state, state_next;

  logic [CW-1:0] ra, ra_next;
  logic [CW-1:0] rb, rb_next;
  logic [PW-1:0] pos, pos_next;
  logic          out_valid_next;
  logic          load_out;
  logic          take_a;
  logic [CW-1:0] ra_m1;
  logic [CW-1:0] rb_m1;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] total;

  assign ra_m1  = ra - CW'(1);
  assign rb_m1  = rb - CW'(1);
  assign pos_m1 = pos - PW'(1);
  assign total  = PW'(cmd.cnt_a) + PW'(cmd.cnt_b);

  assign rd_addr_a = ra_m1[AW-1:0];
  assign rd_addr_b = rb_m1[AW-1:0];
  assign idle      = (state == slm_pkg::ST_IDLE);

  // Greater tail wins; a tie goes to the second list.
  always_comb begin
    priority if (ra == '0) begin
      take_a = 1'b0;
    end else if (rb == '0) begin
      take_a = 1'b1;
    end else begin
      take_a = $signed(rd_data_a) > $signed(rd_data_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slm_pkg::ST_IDLE;
      ra        <= '0;
      rb        <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ra        <= ra_next;
      rb        <= rb_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ra_next        = ra;
    rb_next        = rb;
    pos_next       = pos;
    out_valid_next = out_valid;
    load_out       = 1'b0;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        if (cmd.start && (total != '0)) begin
          ra_next    = cmd.cnt_a;
          rb_next    = cmd.cnt_b;
          pos_next   = total;
          state_next = slm_pkg::ST_READ;
        end
      end
      slm_pkg::ST_READ: begin
        state_next = slm_pkg::ST_PICK;
      end
      slm_pkg::ST_PICK: begin
        load_out       = 1'b1;
        out_valid_next = 1'b1;
        pos_next       = pos_m1;
        if (take_a) begin
          ra_next = ra_m1;
        end else begin
          rb_next = rb_m1;
        end
        state_next = slm_pkg::ST_OUT;
      end
      slm_pkg::ST_OUT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          state_next     = (pos == '0) ? slm_pkg::ST_IDLE : slm_pkg::ST_READ;
        end
      end
      default: begin
        state_next = slm_pkg::ST_IDLE;
      end
    endcase
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_position <= pos_m1[slm_pkg::POS_W-1:0];
      out_value    <= take_a ? rd_data_a : rd_data_b;
      out_last     <= (pos == PW'(1));
      out_dropped  <= cmd.dropped;
    end
  end

endmodule
`default_nettype wire

// ===== src/sorted_list_merge_top.sv =====
// Top level of the sorted list merge block: load side, list buffers and merge sequencer.
//
// Usage:
//   The slave stream carries requests. s_tuser selects the request: append to the
//   first list, append to the second list, or start a merge; s_tdata carries the
//   signed value to append. Each list holds up to LIST_DEPTH ascending values.
//   An append to a full list is dropped and sets a sticky dropped flag that only
//   reset clears. A start streams the merged list on the master side, highest
//   position first, one transaction per element with its position, value, the
//   dropped flag, and tlast on position 0. Both counts clear at the start; with
//   both lists empty a start gives nothing. Merge steps: each element passes the
//   states ST_READ (read both tails from the list memories), ST_PICK (compare and
//   register the result) and ST_OUT (hand it off), set by the registered memory
//   read and the single shared compare. A merge occupies the block until its last
//   element is handed off, master stalls included; s_tready stays low meanwhile.
//   Reset clears the counts, the dropped flag and the sequencer; list contents are
//   not cleared. A stalled master simply holds the current result.
`default_nettype none
module sorted_list_merge_top #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // slave stream: requests
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [slm_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] value
  input  wire logic [slm_pkg::REQ_W-1:0]         s_tuser,   // [1:0] req_type
  // master stream: merged elements
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [slm_pkg::M_TDATA_W-1:0]     m_tdata,   // [5:0] position, [37:6] value_res
  output logic                                   m_tlast,   // last
  output logic                                   m_tuser    // [0] dropped
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = slm_pkg::CNT_W;
  localparam int PAD_W = slm_pkg::M_TDATA_W - slm_pkg::POS_W - slm_pkg::VAL_W;

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic          overflow_seen;

  logic          accept;
  slm_pkg::req_t req;
  logic          full_a;
  logic          full_b;
  logic          wr_a;
  logic          wr_b;
  logic          idle;

  slm_pkg::merge_cmd_t cmd;

  logic [AW-1:0]                rd_addr_a;
  logic [AW-1:0]                rd_addr_b;
  logic [slm_pkg::VAL_W-1:0]    rd_data_a;
  logic [slm_pkg::VAL_W-1:0]    rd_data_b;
  logic [slm_pkg::POS_W-1:0]    out_position;
  logic [slm_pkg::VAL_W-1:0]    out_value;

  // Take requests only while no merge is running.
  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;
  assign req      = slm_pkg::req_t'(s_tuser);

  assign full_a = (count_a >= CW'(LIST_DEPTH));
  assign full_b = (count_b >= CW'(LIST_DEPTH));
  assign wr_a   = accept && (req == slm_pkg::REQ_APPEND_A) && !full_a;
  assign wr_b   = accept && (req == slm_pkg::REQ_APPEND_B) && !full_b;

  // Hand the current counts to the sequencer; it keeps its own copies.
  assign cmd.start   = accept && (req == slm_pkg::REQ_START);
  assign cmd.cnt_a   = count_a;
  assign cmd.cnt_b   = count_b;
  assign cmd.dropped = overflow_seen;

  // Fill counts and sticky drop flag; clear counts when a merge starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.start) begin
        count_a <= '0;
        count_b <= '0;
      end else begin
        if (wr_a) begin
          count_a <= count_a + CW'(1);
        end
        if (wr_b) begin
          count_b <= count_b + CW'(1);
        end
      end
      if (accept && (((req == slm_pkg::REQ_APPEND_A) && full_a) ||
                     ((req == slm_pkg::REQ_APPEND_B) && full_b))) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  slm_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a[AW-1:0]),
    .wr_data (s_tdata),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  slm_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b[AW-1:0]),
    .wr_data (s_tdata),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  slm_merge_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_merge_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idle         (idle),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_position (out_position),
    .out_value    (out_value),
    .out_last     (m_tlast),
    .out_dropped  (m_tuser)
  );

  // Pack the result: position low, value above it, zero pad to whole bytes.
  assign m_tdata = {{PAD_W{1'b0}}, out_value, out_position};

endmodule
`default_nettype wire

// ===== bench/tb_sorted_list_merge_top.sv =====
// Self-checking bench for the sorted list merge block: directed table, random list sets, scoreboard.
`default_nettype none
module tb_sorted_list_merge_top;

  localparam int DEPTH       = slm_pkg::LIST_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;  // well above the slowest legal run
  localparam int DRAIN_WAIT  = 16;

  // One merged element as it shows up on the master stream.
  typedef struct packed {
    logic [slm_pkg::POS_W-1:0]        pos;
    logic signed [slm_pkg::VAL_W-1:0] val;
    logic                             last;
    logic                             dropped;
  } merged_elem_t;

  // One row of the directed table; typed rows carry their single result by hand.
  typedef struct packed {
    slm_pkg::req_t req;
    logic [31:0]   val;
    logic          typed;
    merged_elem_t  res;
  } stim_row_t;

  localparam merged_elem_t NO_RES = '0;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [slm_pkg::S_TDATA_W-1:0]  s_tdata;   // [31:0] value
  logic [slm_pkg::REQ_W-1:0]      s_tuser;   // [1:0] req_type
  logic                           m_tvalid;
  logic                           m_tready;
  logic [slm_pkg::M_TDATA_W-1:0]  m_tdata;   // [5:0] position, [37:6] value_res
  logic                           m_tlast;   // last
  logic                           m_tuser;   // [0] dropped

  sorted_list_merge_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the block: both list buffers, their fill counts and the sticky flag.
  logic signed [slm_pkg::VAL_W-1:0] shadow_a [DEPTH];
  logic signed [slm_pkg::VAL_W-1:0] shadow_b [DEPTH];
  int unsigned                      fill_a;
  int unsigned                      fill_b;
  bit                               drop_seen;

  merged_elem_t merged_due [$];  // merged elements still owed by the block
  int           err_count;
  int           items_sent;      // requests that are not the unused code
  int           cycle_count;
  int           stall_left;
  bit           idle_on;
  stim_row_t    dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: anything past the limit means the block hung.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Apply one accepted request to the shadow state and queue whatever it merges out.
  task automatic track_request(input slm_pkg::req_t req, input logic [31:0] val,
                               input bit typed, input merged_elem_t typed_res);
    int unsigned  left_a;
    int unsigned  left_b;
    int unsigned  pos;
    merged_elem_t elem;
    case (req)
      slm_pkg::REQ_APPEND_A: begin
        if (fill_a < DEPTH) begin
          shadow_a[fill_a] = val;
          fill_a++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      slm_pkg::REQ_APPEND_B: begin
        if (fill_b < DEPTH) begin
          shadow_b[fill_b] = val;
          fill_b++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      slm_pkg::REQ_START: begin
        left_a = fill_a;
        left_b = fill_b;
        // Walk from the top position down; a tie goes to the second list.
        for (pos = fill_a + fill_b; pos > 0; pos--) begin
          if (left_a == 0) begin
            elem.val = shadow_b[left_b-1];
            left_b--;
          end else if (left_b == 0) begin
            elem.val = shadow_a[left_a-1];
            left_a--;
          end else if (shadow_a[left_a-1] > shadow_b[left_b-1]) begin
            elem.val = shadow_a[left_a-1];
            left_a--;
          end else begin
            elem.val = shadow_b[left_b-1];
            left_b--;
          end
          elem.pos     = slm_pkg::POS_W'(pos - 1);
          elem.last    = (pos == 1);
          elem.dropped = drop_seen;
          merged_due.push_back(typed ? typed_res : elem);
        end
        fill_a = 0;
        fill_b = 0;
      end
      default: ;  // unused code: drop it, no state change
    endcase
  endtask

  // Present one request at the falling edge and hold it until the transaction completes.
  task automatic send_request(input slm_pkg::req_t req, input logic [31:0] val,
                              input bit typed, input merged_elem_t typed_res);
    int gap;
    bit taken;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = s_tready;
    end
    track_request(req, val, typed, typed_res);
    if (req != slm_pkg::REQ_NONE) items_sent++;
  endtask

  // Build one list's contents: ascending with a random stride, or plain noise.
  task automatic gen_list(input int n, input bit ordered, ref logic [31:0] vals [$]);
    longint      cur;
    int unsigned stride_max;
    vals.delete();
    case ($urandom_range(0, 3))
      0: stride_max = 0;          // all duplicates
      1: stride_max = 3;
      2: stride_max = 4096;
      default: stride_max = 1 << 26;
    endcase
    cur = longint'(int'($urandom));
    if ($urandom_range(0, 7) == 0) cur = -64'sd2147483648;
    for (int k = 0; k < n; k++) begin
      if (!ordered) begin
        vals.push_back($urandom);
      end else begin
        vals.push_back(cur[31:0]);
        cur += $urandom_range(0, stride_max);
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end
    end
  endtask

  // Mostly short lists, some mid-size, a few full (or overfull once drops are allowed).
  function automatic int pick_len(input bit allow_over);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 6);
    if (r < 9) return $urandom_range(7, DEPTH - 1);
    return allow_over ? $urandom_range(DEPTH, DEPTH + 2) : DEPTH;
  endfunction

  // Load two lists in random interleave, sprinkle unused codes, then start the merge.
  task automatic run_merge_set(input int len_a, input int len_b);
    logic [31:0] vals_a [$];
    logic [31:0] vals_b [$];
    int          ia;
    int          ib;
    bit          ordered;
    ordered = ($urandom_range(0, 7) != 0);
    gen_list(len_a, ordered, vals_a);
    gen_list(len_b, ordered, vals_b);
    ia = 0;
    ib = 0;
    while (ia < vals_a.size() || ib < vals_b.size()) begin
      if ($urandom_range(0, 15) == 0)
        send_request(slm_pkg::REQ_NONE, $urandom, 1'b0, NO_RES);
      if (ib == vals_b.size() || (ia < vals_a.size() && $urandom_range(0, 1) == 1)) begin
        send_request(slm_pkg::REQ_APPEND_A, vals_a[ia], 1'b0, NO_RES);
        ia++;
      end else begin
        send_request(slm_pkg::REQ_APPEND_B, vals_b[ib], 1'b0, NO_RES);
        ib++;
      end
    end
    send_request(slm_pkg::REQ_START, $urandom, 1'b0, NO_RES);
  endtask

  function automatic stim_row_t mk_row(input slm_pkg::req_t req, input logic [31:0] val,
                                       input bit typed, input merged_elem_t res);
    stim_row_t row;
    row.req   = req;
    row.val   = val;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  // Master side: ready drops in random bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Scoreboard: compare every master transaction with the oldest owed element.
  always @(posedge clk) begin : check_merged
    merged_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (merged_due.size() == 0) begin
        $display("%0t: expected no transaction, got position %0d value %h", $time,
                 m_tdata[5:0], m_tdata[37:6]);
        err_count++;
      end else begin
        want = merged_due.pop_front();
        if (m_tdata[5:0] !== want.pos) begin
          $display("%0t: position expected %0d, got %0d", $time, want.pos, m_tdata[5:0]);
          err_count++;
        end
        if (m_tdata[37:6] !== want.val) begin
          $display("%0t: value expected %h, got %h", $time, want.val, m_tdata[37:6]);
          err_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %b, got %b", $time, want.last, m_tlast);
          err_count++;
        end
        if (m_tuser !== want.dropped) begin
          $display("%0t: dropped expected %b, got %b", $time, want.dropped, m_tuser);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = slm_pkg::REQ_NONE;
    m_tready    = 1'b0;
    stall_left  = 0;
    idle_on     = 1'b1;
    err_count   = 0;
    items_sent  = 0;
    cycle_count = 0;
    fill_a      = 0;
    fill_b      = 0;
    drop_seen   = 1'b0;

    // Directed table: empty start, unused code, single extremes, ties, one list running dry.
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h0000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_NONE,     32'hFFFF_FFFF, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'h8000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h0000_0000, 1'b1,
                              '{6'd0, 32'h8000_0000, 1'b1, 1'b0}));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'h7FFF_FFFF, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'hFFFF_FFFF, 1'b1,
                              '{6'd0, 32'h7FFF_FFFF, 1'b1, 1'b0}));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'd5,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'd5,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h0000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'hFFFF_FFFF, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'd3,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'd7,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h0000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'd1,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'd2,         1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'hFFFF_FFFB, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h0000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'h8000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_A, 32'h7FFF_FFFF, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'h8000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_APPEND_B, 32'h7FFF_FFFF, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_NONE,     32'h0000_0000, 1'b0, NO_RES));
    dir_rows.push_back(mk_row(slm_pkg::REQ_START,    32'h5A5A_A5A5, 1'b0, NO_RES));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      send_request(dir_rows[k].req, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].res);

    // Random sets with the sticky flag still clear; keep lists within capacity.
    while (items_sent < 280) begin
      idle_on = ($urandom_range(0, 4) != 0);
      run_merge_set(pick_len(1'b0), pick_len(1'b0));
    end

    // Force overflow on both lists; the flag stays set from here on.
    idle_on = 1'b1;
    run_merge_set(DEPTH + 1, DEPTH + 2);

    // Random sets with drops allowed; run the tail with no idling on either side.
    while (items_sent < 460) begin
      idle_on = (items_sent < 400) && ($urandom_range(0, 4) != 0);
      run_merge_set(pick_len(1'b1), pick_len(1'b1));
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    idle_on = 1'b0;

    // Drain: wait for every owed element, then hold a little longer for strays.
    while (merged_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
